[rtl/cpcr_pkg.sv]
// shared types and constants for the circle pair collision resolver
// no dependencies; imported by circle_pair_collision_resolve
package cpcr_pkg;

    localparam int POS_W         = 24;
    localparam int RAD_W         = 16;
    localparam int FLOOR_W       = 23;
    localparam int GAIN_W        = 9;
    localparam int POS_FRAC_BITS = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 23;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(800 << POS_FRAC_BITS);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(192);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_Y       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_GAIN = 1'b1;

    // pipeline map
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 17;
    localparam int ST_SQRT0   = 3;
    localparam int ST_PREP    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_GAIN    = ST_PREP + 1;
    localparam int ST_NUM     = ST_PREP + 2;
    localparam int ST_DIVIN   = ST_PREP + 3;
    localparam int ST_DIV0    = ST_DIVIN + 1;
    localparam int ST_SUM     = ST_DIV0 + DIV_STEPS;
    localparam int NUM_STAGES = ST_SUM + 2;

    typedef struct packed {
        logic signed [23:0] x1;
        logic signed [23:0] y1;
        logic signed [23:0] x2;
        logic signed [23:0] y2;
        logic [15:0]        r1;
        logic [15:0]        r2;
        logic               sdx;
        logic               sdy;
        logic [24:0]        adx;
        logic [24:0]        ady;
        logic [16:0]        rsum;
        logic [49:0]        sqx;
        logic [49:0]        sqy;
        logic [33:0]        rsum_sq;
        logic               touch;
        logic               coin;
        logic [33:0]        sq_rem;
        logic [16:0]        root;
        logic [16:0]        pen;
        logic [33:0]        dsum;
        logic [3:0][32:0]   prod;
        logic [25:0]        kgain;
        logic [3:0][58:0]   num;
        logic [3:0][50:0]   rem;
        logic [3:0][16:0]   quo;
        logic signed [26:0] nx1;
        logic signed [26:0] ny1;
        logic signed [26:0] nx2;
        logic signed [26:0] ny2;
        logic signed [26:0] ey1;
        logic signed [26:0] ey2;
        logic signed [23:0] ox1;
        logic signed [23:0] oy1;
        logic signed [23:0] ox2;
        logic signed [23:0] oy2;
    } pipe_t;

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        logic signed [23:0] r;
        if (v > 27'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -27'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

[rtl/circle_pair_collision_resolve.sv]
// circle pair collision resolver, top level
// depends on cpcr_pkg (types, constants, saturation helper)
//
// Takes one pair of circles per word and returns one word with the corrected
// centres and the touching / coincident flags. Overlapping circles are pushed
// apart along the centre line, the push shared by the other circle's radius
// share and scaled by response_gain; a circle whose moved lower edge reaches
// floor_y keeps its y. A new pair is accepted in every cycle unless a stalled
// output has filled the pipe. The depth is set by the 17-step square root
// (one root bit per stage) and the four 17-step restoring dividers (one
// quotient bit per stage) running side by side. Each stage advances when it
// is empty or the next stage advances, so bubbles close up and input is taken
// while a result waits at the output. The user writes floor_y and response_gain
// through the cfg port only while idle; the block does not enforce this.
module circle_pair_collision_resolve (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [cpcr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius
    input  logic [127:0]                     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // new_first_x, new_first_y, new_second_x, new_second_y
    output logic [95:0]                      m_tdata,
    // touching, coincident
    output logic [1:0]                       m_tuser
);
    import cpcr_pkg::*;

    logic [FLOOR_W-1:0] floor_reg;
    logic [GAIN_W-1:0]  gain_reg;

    pipe_t                 pipe_reg  [NUM_STAGES];
    pipe_t                 pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   adv;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
            gain_reg  <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FLOOR_Y:       floor_reg <= cfg_wr_data[FLOOR_W-1:0];
                REG_RESPONSE_GAIN: gain_reg  <= cfg_wr_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // stall chain: a stage moves when empty or when its successor moves
    assign adv[NUM_STAGES] = m_tready;
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_adv
        assign adv[i]        = ~valid_reg[i] | adv[i+1];
        assign valid_next[i] = (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i-1];
    end
    assign s_tready = adv[0];

    // stage 0: unpack, centre deltas, radius sum
    always_comb begin
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        pipe_next[0]    = '0;
        pipe_next[0].x1 = s_tdata[23:0];
        pipe_next[0].y1 = s_tdata[47:24];
        pipe_next[0].r1 = s_tdata[63:48];
        pipe_next[0].x2 = s_tdata[87:64];
        pipe_next[0].y2 = s_tdata[111:88];
        pipe_next[0].r2 = s_tdata[127:112];
        dx = {s_tdata[23], s_tdata[23:0]} - {s_tdata[87], s_tdata[87:64]};
        dy = {s_tdata[47], s_tdata[47:24]} - {s_tdata[111], s_tdata[111:88]};
        pipe_next[0].sdx  = dx[24];
        pipe_next[0].sdy  = dy[24];
        pipe_next[0].adx  = dx[24] ? 25'(-dx) : 25'(dx);
        pipe_next[0].ady  = dy[24] ? 25'(-dy) : 25'(dy);
        pipe_next[0].rsum = 17'(s_tdata[63:48]) + 17'(s_tdata[127:112]);
    end

    // stage 1: squares
    always_comb begin
        pipe_next[1]         = pipe_reg[0];
        pipe_next[1].sqx     = 50'(pipe_reg[0].adx) * 50'(pipe_reg[0].adx);
        pipe_next[1].sqy     = 50'(pipe_reg[0].ady) * 50'(pipe_reg[0].ady);
        pipe_next[1].rsum_sq = 34'(pipe_reg[0].rsum) * 34'(pipe_reg[0].rsum);
    end

    // stage 2: squared distance, overlap test
    always_comb begin
        logic [50:0] d2;
        pipe_next[2] = pipe_reg[1];
        d2 = 51'(pipe_reg[1].sqx) + 51'(pipe_reg[1].sqy);
        pipe_next[2].touch  = d2 < 51'(pipe_reg[1].rsum_sq);
        pipe_next[2].coin   = (d2 < 51'(pipe_reg[1].rsum_sq)) && (d2 == '0);
        // below the radius sum the squared distance fits 34 bits
        pipe_next[2].sq_rem = d2[33:0];
        pipe_next[2].root   = '0;
    end

    // square root, one root bit per stage, msb first
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - g;
        always_comb begin
            logic [35:0] trial;
            pipe_next[ST_SQRT0+g] = pipe_reg[ST_SQRT0+g-1];
            trial = (36'(pipe_reg[ST_SQRT0+g-1].root) << (B + 1)) | (36'(1) << (2 * B));
            if (36'(pipe_reg[ST_SQRT0+g-1].sq_rem) >= trial) begin
                pipe_next[ST_SQRT0+g].sq_rem = pipe_reg[ST_SQRT0+g-1].sq_rem - trial[33:0];
                pipe_next[ST_SQRT0+g].root   = pipe_reg[ST_SQRT0+g-1].root | (17'(1) << B);
            end
        end
    end

    // penetration, divisor base, magnitude times other radius
    always_comb begin
        pipe_t p;
        p = pipe_reg[ST_PREP-1];
        pipe_next[ST_PREP]         = p;
        pipe_next[ST_PREP].pen     = p.rsum - p.root;
        pipe_next[ST_PREP].dsum    = 34'(p.root) * 34'(p.rsum);
        pipe_next[ST_PREP].prod[0] = 33'(p.adx[16:0]) * 33'(p.r2);
        pipe_next[ST_PREP].prod[1] = 33'(p.ady[16:0]) * 33'(p.r2);
        pipe_next[ST_PREP].prod[2] = 33'(p.adx[16:0]) * 33'(p.r1);
        pipe_next[ST_PREP].prod[3] = 33'(p.ady[16:0]) * 33'(p.r1);
    end

    always_comb begin
        pipe_next[ST_GAIN]       = pipe_reg[ST_GAIN-1];
        pipe_next[ST_GAIN].kgain = 26'(gain_reg) * 26'(pipe_reg[ST_GAIN-1].pen);
    end

    always_comb begin
        pipe_next[ST_NUM] = pipe_reg[ST_NUM-1];
        for (int c = 0; c < 4; c++) begin
            pipe_next[ST_NUM].num[c] = 59'(pipe_reg[ST_NUM-1].prod[c])
                                     * 59'(pipe_reg[ST_NUM-1].kgain);
        end
    end

    // add half the divisor, fold the factor 512 into the dividend
    always_comb begin
        logic [59:0] acc;
        pipe_next[ST_DIVIN] = pipe_reg[ST_DIVIN-1];
        acc = '0;
        for (int c = 0; c < 4; c++) begin
            acc = 60'(pipe_reg[ST_DIVIN-1].num[c]) + (60'(pipe_reg[ST_DIVIN-1].dsum) << 8);
            pipe_next[ST_DIVIN].rem[c] = acc[59:9];
            pipe_next[ST_DIVIN].quo[c] = '0;
        end
    end

    // four restoring dividers, one quotient bit per stage
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        localparam int K = DIV_STEPS - 1 - g;
        always_comb begin
            logic [50:0] dk;
            pipe_next[ST_DIV0+g] = pipe_reg[ST_DIV0+g-1];
            dk = 51'(pipe_reg[ST_DIV0+g-1].dsum) << K;
            for (int c = 0; c < 4; c++) begin
                if (pipe_reg[ST_DIV0+g-1].rem[c] >= dk) begin
                    pipe_next[ST_DIV0+g].rem[c]    = pipe_reg[ST_DIV0+g-1].rem[c] - dk;
                    pipe_next[ST_DIV0+g].quo[c][K] = 1'b1;
                end
            end
        end
    end

    // signed moves and candidate positions
    always_comb begin
        pipe_t p;
        logic signed [26:0] mv [4];
        p = pipe_reg[ST_SUM-1];
        for (int c = 0; c < 4; c++) begin
            if ((c == 0 || c == 2) ? p.sdx : p.sdy) begin
                mv[c] = -$signed(27'(p.quo[c]));
            end else begin
                mv[c] = $signed(27'(p.quo[c]));
            end
        end
        pipe_next[ST_SUM]     = p;
        pipe_next[ST_SUM].nx1 = 27'(p.x1) + mv[0];
        pipe_next[ST_SUM].ny1 = 27'(p.y1) + mv[1];
        pipe_next[ST_SUM].nx2 = 27'(p.x2) - mv[2];
        pipe_next[ST_SUM].ny2 = 27'(p.y2) - mv[3];
        pipe_next[ST_SUM].ey1 = 27'(p.y1) + $signed(27'(p.r1)) + mv[1];
        pipe_next[ST_SUM].ey2 = 27'(p.y2) + $signed(27'(p.r2)) - mv[3];
    end

    // floor test, saturation, pass-through when no move
    always_comb begin
        pipe_t p;
        logic signed [26:0] fl;
        p  = pipe_reg[ST_SUM];
        fl = $signed(27'(floor_reg));
        pipe_next[ST_SUM+1] = p;
        if (p.touch && !p.coin) begin
            pipe_next[ST_SUM+1].ox1 = sat24(p.nx1);
            pipe_next[ST_SUM+1].oy1 = (p.ey1 >= fl) ? p.y1 : sat24(p.ny1);
            pipe_next[ST_SUM+1].ox2 = sat24(p.nx2);
            pipe_next[ST_SUM+1].oy2 = (p.ey2 >= fl) ? p.y2 : sat24(p.ny2);
        end else begin
            pipe_next[ST_SUM+1].ox1 = p.x1;
            pipe_next[ST_SUM+1].oy1 = p.y1;
            pipe_next[ST_SUM+1].ox2 = p.x2;
            pipe_next[ST_SUM+1].oy2 = p.y2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {pipe_reg[NUM_STAGES-1].oy2, pipe_reg[NUM_STAGES-1].ox2,
                       pipe_reg[NUM_STAGES-1].oy1, pipe_reg[NUM_STAGES-1].ox1};
    assign m_tuser  = {pipe_reg[NUM_STAGES-1].coin, pipe_reg[NUM_STAGES-1].touch};

    // input only blocks when the whole pipe is full behind a stalled output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // finished root leaves a remainder no larger than twice the root
    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_PREP-1] && pipe_reg[ST_PREP-1].touch) |->
        (35'(pipe_reg[ST_PREP-1].sq_rem) <= 35'({pipe_reg[ST_PREP-1].root, 1'b0})))
        else $error("square root remainder out of range");

    // finished quotients leave remainders below the divisor
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_SUM-1] && pipe_reg[ST_SUM-1].touch && !pipe_reg[ST_SUM-1].coin) |->
        ((pipe_reg[ST_SUM-1].rem[0] < 51'(pipe_reg[ST_SUM-1].dsum)) &&
         (pipe_reg[ST_SUM-1].rem[1] < 51'(pipe_reg[ST_SUM-1].dsum)) &&
         (pipe_reg[ST_SUM-1].rem[2] < 51'(pipe_reg[ST_SUM-1].dsum)) &&
         (pipe_reg[ST_SUM-1].rem[3] < 51'(pipe_reg[ST_SUM-1].dsum))))
        else $error("divider remainder not below divisor");

    a_coin_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
        else $error("coincident flagged without touching");

endmodule
